// File: rtl/core/glmc_pkg.sv
// Shared types and constants for the grid local minimum counter.
package glmc_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int SAMPLE_W    = 32;
  localparam int COUNT_W     = 21;
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(1);

  localparam logic [CFG_W-1:0]   SIZE_MIN  = CFG_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // position of a sample relative to the frame edges
  typedef struct packed {
    logic last_col;
    logic last_row;
    logic row_first;
    logic row_second;
    logic col_first;
    logic col_second;
  } pos_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] mid;
    pos_t                pos;
  } entry_t;

  // [row][col], row 0 oldest line, col 0 oldest column
  typedef logic [2:0][2:0][SAMPLE_W-1:0] win_t;

endpackage

// File: rtl/core/glmc_ram.sv
// Generic simple dual-port RAM with registered read.
module glmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/glmc_front.sv
// Front end: config registers, raster position, line buffer access.
module glmc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [glmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [glmc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [glmc_pkg::SAMPLE_W-1:0]    sample_value,
  input  logic                             q_full,
  output logic                             q_push,
  output glmc_pkg::entry_t                 q_data
);
  import glmc_pkg::*;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic [CFG_W-1:0]      row_count;
  logic [CFG_W-1:0]      column_count;
  logic [ROW_W-1:0]      row_pos;
  logic [COL_W-1:0]      col_pos;
  logic [CFG_W-1:0]      rows_eff;
  logic [CFG_W-1:0]      cols_eff;
  logic                  last_col;
  logic                  last_row;
  logic                  accept;
  logic                  s1_adv;
  logic                  s1_valid;
  logic [SAMPLE_W-1:0]   s1_sample;
  logic [COL_W-1:0]      s1_col;
  pos_t                  s1_pos;
  logic [2*SAMPLE_W-1:0] lb_rd_data;

  assign rows_eff = clamp_size(row_count, CFG_W'(MAX_ROWS));
  assign cols_eff = clamp_size(column_count, CFG_W'(MAX_COLUMNS));
  assign last_col = (CFG_W'(col_pos) + CFG_W'(1)) >= cols_eff;
  assign last_row = (CFG_W'(row_pos) + CFG_W'(1)) >= rows_eff;

  assign sample_stall = s1_valid && q_full;
  assign accept       = sample_valid && !sample_stall;
  assign s1_adv       = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= SIZE_MIN;
      column_count <= SIZE_MIN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      col_pos  <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && q_full);
      if (accept) begin
        if (last_col) begin
          col_pos <= '0;
          row_pos <= last_row ? '0 : row_pos + ROW_W'(1);
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample         <= sample_value;
      s1_col            <= col_pos;
      s1_pos.last_col   <= last_col;
      s1_pos.last_row   <= last_row;
      s1_pos.row_first  <= (row_pos == ROW_W'(0));
      s1_pos.row_second <= (row_pos == ROW_W'(1));
      s1_pos.col_first  <= (col_pos == COL_W'(0));
      s1_pos.col_second <= (col_pos == COL_W'(1));
    end
  end

  // each entry holds {upper line, middle line} for one column
  glmc_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({lb_rd_data[SAMPLE_W-1:0], s1_sample}),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (lb_rd_data)
  );

  assign q_push        = s1_adv;
  assign q_data.sample = s1_sample;
  assign q_data.up     = lb_rd_data[2*SAMPLE_W-1:SAMPLE_W];
  assign q_data.mid    = lb_rd_data[SAMPLE_W-1:0];
  assign q_data.pos    = s1_pos;

endmodule

// File: rtl/core/glmc_queue.sv
// Short word queue between front and back ends.
module glmc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  glmc_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output glmc_pkg::entry_t pop_data,
  output logic             empty
);
  import glmc_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full     = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/glmc_back.sv
// Back end: 3x3 window, minimum test, frame count and result register.
module glmc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  glmc_pkg::entry_t              q_data,
  output logic                          q_pop,
  output logic                          count_valid,
  input  logic                          count_stall,
  output logic [glmc_pkg::COUNT_W-1:0]  minimum_count
);
  import glmc_pkg::*;

  // strict minimum test of window cell (wr, wc) against in-frame neighbors
  function automatic logic cand_min(input win_t w, input logic [2:0] rok,
                                    input logic [2:0] cok, input int wr, input int wc);
    logic ok;
    int   rr;
    int   cc;
    ok = rok[wr] && cok[wc];
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        rr = wr + dr - 1;
        cc = wc + dc - 1;
        if (!(dr == 1 && dc == 1) && rr >= 0 && rr <= 2 && cc >= 0 && cc <= 2) begin
          if (rok[rr] && cok[cc]) begin
            ok = ok && ($signed(w[wr][wc]) < $signed(w[rr][cc]));
          end
        end
      end
    end
    return ok;
  endfunction

  logic               en;
  win_t               win;
  logic               b1_valid;
  pos_t               b1_pos;
  logic [2:0]         row_ok;
  logic [2:0]         col_ok;
  logic               h11;
  logic               h12;
  logic               h21;
  logic               h22;
  logic [2:0]         hits;
  logic               b2_valid;
  logic               b2_last;
  logic [2:0]         b2_hits;
  logic [COUNT_W-1:0] running_count;
  logic [COUNT_W:0]   sum_wide;
  logic [COUNT_W-1:0] sum_sat;

  assign en    = !count_valid || !count_stall;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= q_data.up;
      win[1][2] <= q_data.mid;
      win[2][2] <= q_data.sample;
      b1_pos    <= q_data.pos;
    end
  end

  assign row_ok = {1'b1, !b1_pos.row_first, !b1_pos.row_first && !b1_pos.row_second};
  assign col_ok = {1'b1, !b1_pos.col_first, !b1_pos.col_first && !b1_pos.col_second};

  always_comb begin
    h11  = cand_min(win, row_ok, col_ok, 1, 1);
    h12  = b1_pos.last_col && cand_min(win, row_ok, col_ok, 1, 2);
    h21  = b1_pos.last_row && cand_min(win, row_ok, col_ok, 2, 1);
    h22  = b1_pos.last_row && b1_pos.last_col && cand_min(win, row_ok, col_ok, 2, 2);
    hits = 3'(h11) + 3'(h12) + 3'(h21) + 3'(h22);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_hits <= hits;
      b2_last <= b1_pos.last_row && b1_pos.last_col;
    end
  end

  assign sum_wide = {1'b0, running_count} + (COUNT_W+1)'(b2_hits);
  assign sum_sat  = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid      <= 1'b0;
      b2_valid      <= 1'b0;
      running_count <= '0;
      count_valid   <= 1'b0;
    end else begin
      if (en) begin
        b1_valid <= q_pop;
        b2_valid <= b1_valid;
      end
      if (en && b2_valid) begin
        running_count <= b2_last ? '0 : sum_sat;
        count_valid   <= b2_last;
      end else if (count_valid && !count_stall) begin
        count_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && b2_valid && b2_last) begin
      minimum_count <= sum_sat;
    end
  end

endmodule

// File: rtl/core/grid_strict_local_minimum_counter_unit.sv
// Top level of the grid strict local minimum counter.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-----------------------
//  sample   | in        | sample_valid / sample_stall | sample_value[31:0]
//  count    | out       | count_valid / count_stall   | minimum_count[20:0]
//  config   | in        | cfg_write                   | cfg_index, cfg_data
//
// One sample word per cycle while sample_stall is low; a frame's count passes
// the sample register, queue write, window shift, test register and count
// register after its last sample is accepted. The line buffer is one 1024 x 64
// RAM, one read and one write per cycle. Reset needs no clearing pass. A stalled
// count holds the back end; the 4-entry queue absorbs it before sample_stall rises.
module grid_strict_local_minimum_counter_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [glmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [glmc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [glmc_pkg::SAMPLE_W-1:0]    sample_value,
  output logic                             count_valid,
  input  logic                             count_stall,
  output logic [glmc_pkg::COUNT_W-1:0]     minimum_count
);
  import glmc_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_in;
  entry_t q_out;

  glmc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_value (sample_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  glmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  glmc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .count_valid   (count_valid),
    .count_stall   (count_stall),
    .minimum_count (minimum_count)
  );

endmodule

// File: rtl/core/glmc_checker.sv
// Port-level checker for the grid local minimum counter, bound to the top.
module glmc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             sample_stall,
  input logic                             count_valid,
  input logic                             count_stall,
  input logic [glmc_pkg::COUNT_W-1:0]     minimum_count
);

  a_count_hold_valid: assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> count_valid)
    else $error("count word dropped while stalled");

  a_count_hold_data: assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> $stable(minimum_count))
    else $error("count word changed while stalled");

  a_reset_no_count: assert property (@(posedge clk)
    rst |=> !count_valid)
    else $error("count word present right after reset");

  a_reset_no_stall: assert property (@(posedge clk)
    rst |=> !sample_stall)
    else $error("sample stall right after reset");

endmodule

bind grid_strict_local_minimum_counter_unit glmc_checker u_checker (.*);
